// ===== rtl/core/hashed_timer_wheel_unit_defines.svh =====
// Assertion macros used by the timer wheel unit RTL
`ifndef HASHED_TIMER_WHEEL_UNIT_DEFINES_SVH
`define HASHED_TIMER_WHEEL_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define HTW_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset
`define HTW_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/htw_pkg.sv =====
`timescale 1ns / 1ps
package htw_pkg;
	localparam int unsigned IdW = 5;
	localparam int unsigned CntW = 11;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_TICK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	// Command broadcast along the cell row
	typedef struct packed {
		logic        add;
		logic        del;
		logic        tick;
		logic [15:0] slot;
		logic [31:0] rot;
		logic [15:0] cur;
	} cell_cmd_t;
endpackage

// ===== rtl/core/hashed_timer_wheel_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: operation[1:0] timeout_ticks[33:2] target_timer[38:34]
// m_axis    out  tdata: status[1:0] timer_id[6:2] expired[7]; tlast: last_of_run
// cfg       in   cfg_we/cfg_wdata: slot_count
// Add: the timeout passes the 32-step divider before the result; a second division
// follows when the current slot lies beyond a reduced slot count.
// Tick: expired timers are reported one per cycle while the output does not stall;
// the current slot wraps through the divider first when it lies beyond the slot count.
// Reset clears all entries, current slot and sets slot count to 1024.
// Output stalls hold the sequencer; one item is in work at a time, and the next
// input is taken the cycle after the last result transaction.
module hashed_timer_wheel_unit #(
	parameter int unsigned MAX_SLOTS  = 1024,
	parameter int unsigned MAX_TIMERS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // operation, timeout_ticks, target_timer
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // status, timer_id, expired
	output logic        m_axis_tlast,  // last_of_run
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata
);
	import htw_pkg::*;
	`include "hashed_timer_wheel_unit_defines.svh"

	localparam int unsigned Pool = (MAX_TIMERS < 32) ? MAX_TIMERS : 32;

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_ADD, S_SCAN, S_EMIT, S_OUT, S_MOD, S_WRAP
	} state_t;

	state_t      state_q;
	logic [10:0] slot_count_q;
	logic [15:0] cur_q;
	logic [1:0]  op_q;
	logic [31:0] tmo_q;
	logic [4:0]  tgt_q;
	logic        any_q;
	logic [7:0]  out_data_q;
	logic        out_last_q;
	logic        out_valid_q;
	logic [31:0] rot_q;
	logic [15:0] slot_q;
	cell_cmd_t   cmd;
	logic        div_start, div_done;
	logic [31:0] quo;
	logic [15:0] rem;
	logic [15:0] n_eff;
	logic [16:0] slot_sum;
	logic [16:0] mod_arg;
	logic [31:0] div_dividend;
	logic [31:0] valid_ext;
	logic [Pool:0] chain;
	logic [Pool-1:0] valid_v, fire_v, fire_clr;
	logic [4:0]  first_id;
	logic        first_found;
	logic        more_fire;

	always_comb begin
		if (slot_count_q == '0) n_eff = 16'd1;
		else if (32'(slot_count_q) > MAX_SLOTS) n_eff = 16'(MAX_SLOTS);
		else n_eff = {5'd0, slot_count_q};
	end

	// second pass reduces cur + rem (add) or cur + 1 (tick) modulo the slot count
	assign mod_arg      = (state_q == S_WRAP) ? ({1'b0, cur_q} + 17'd1) : slot_sum;
	assign div_dividend = (state_q == S_DIV) ? tmo_q : {15'd0, mod_arg};

	htw_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(n_eff), .done(div_done), .quotient(quo), .remainder(rem)
	);

	assign slot_sum = {1'b0, cur_q} + {1'b0, rem};
	assign cmd.add  = (state_q == S_ADD);
	assign cmd.del  = (state_q == S_OUT) && (op_q == OP_DEL) && !out_valid_q;
	assign cmd.tick = (state_q == S_SCAN);
	assign cmd.slot = slot_q;
	assign cmd.rot  = rot_q;
	assign cmd.cur  = cur_q;
	assign chain[0] = 1'b1;
	assign valid_ext = 32'(valid_v);

	genvar g;
	generate
		for (g = 0; g < Pool; g++) begin : g_cell
			htw_cell u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd),
				.sel_del(tgt_q == 5'(g)), .take_in(chain[g]), .take_out(chain[g+1]),
				.fire_clr(fire_clr[g]), .valid(valid_v[g]), .fire(fire_v[g])
			);
		end
	endgenerate

	always_comb begin
		first_id = '0;
		first_found = 1'b0;
		for (int i = Pool - 1; i >= 0; i--) begin
			if (fire_v[i]) begin
				first_id = 5'(i);
				first_found = 1'b1;
			end
		end
		fire_clr = '0;
		if (state_q == S_EMIT && (!out_valid_q || m_axis_tready) && first_found)
			fire_clr[first_id] = 1'b1;
		more_fire = ($countones(fire_v) > 1);
	end

	assign div_start = ((state_q == S_DIV) || (state_q == S_MOD) || (state_q == S_WRAP))
	                   && (any_q == 1'b0);
	assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_count_q <= 11'd1024;
			cur_q        <= '0;
			out_valid_q  <= 1'b0;
			any_q        <= 1'b0;
		end else begin
			if (cfg_we) slot_count_q <= cfg_wdata;
			// S_EMIT reloads the output register itself
			if (out_valid_q && m_axis_tready && state_q != S_EMIT) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					op_q  <= s_axis_tdata[1:0];
					tmo_q <= s_axis_tdata[33:2];
					tgt_q <= s_axis_tdata[38:34];
					any_q <= 1'b0;
					unique case (op_t'(s_axis_tdata[1:0]))
						OP_ADD:  state_q <= S_DIV;
						OP_TICK: state_q <= S_SCAN;
						OP_DEL, OP_NONE: state_q <= S_OUT;
						default: state_q <= S_OUT;
					endcase
				end
				S_DIV: begin
					if (!div_done) begin
						any_q <= 1'b1;
					end else if (&valid_v) begin
						out_data_q <= {1'b0, 5'd0, ST_FULL};
						out_last_q <= 1'b1;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						rot_q <= quo;
						if (cur_q < n_eff) begin
							slot_q <= (slot_sum >= {1'b0, n_eff})
							          ? 16'(slot_sum - {1'b0, n_eff}) : slot_sum[15:0];
							state_q <= S_ADD;
						end else begin
							any_q <= 1'b0;
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (!div_done) begin
						any_q <= 1'b1;
					end else begin
						slot_q <= rem;
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					for (int i = 0; i < Pool; i++)
						if (chain[i] && !valid_v[i]) out_data_q <= {1'b0, 5'(i), ST_OK};
					out_last_q  <= 1'b1;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SCAN: begin
					if (cur_q < n_eff) begin
						cur_q <= (({1'b0, cur_q} + 17'd1) >= {1'b0, n_eff}) ? '0
						                                                     : cur_q + 16'd1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (!div_done) begin
						any_q <= 1'b1;
					end else begin
						cur_q <= rem;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: if (!out_valid_q || m_axis_tready) begin
					out_valid_q <= 1'b1;
					if (first_found) begin
						out_data_q <= {1'b1, first_id, ST_OK};
						out_last_q <= !more_fire;
						any_q <= 1'b1;
						if (!more_fire) state_q <= S_IDLE;
					end else begin
						out_data_q <= {1'b0, 5'd0, ST_OK};
						out_last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_OUT: if (!out_valid_q) begin
					if (op_q == OP_DEL) begin
						if (valid_ext[tgt_q])
							out_data_q <= {1'b0, tgt_q, ST_OK};
						else
							out_data_q <= {1'b0, tgt_q, ST_NOTFOUND};
					end else begin
						out_data_q <= {1'b0, 5'd0, ST_OK};
					end
					out_last_q <= 1'b1;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	`HTW_ASSERT_IMP(a_ready_idle, s_axis_tready, state_q == S_IDLE)
	`HTW_ASSERT_IMP(a_fire_onehot_clr, 1'b1, $onehot0(fire_clr))
	`HTW_ASSERT_NXT(a_scan_to_emit, state_q == S_SCAN, state_q == S_EMIT || state_q == S_WRAP)
	`HTW_ASSERT_IMP(a_cur_range, 1'b1, 32'(cur_q) < MAX_SLOTS)
endmodule

// ===== rtl/core/htw_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module htw_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [15:0] remainder
);
	import htw_pkg::*;

	logic [31:0] q_q;
	logic [16:0] r_q;
	logic [15:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [16:0] r_sh;
	logic [17:0] diff;

	assign r_sh = {r_q[15:0], q_q[31]};
	assign diff = {1'b0, r_sh} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				r_q <= diff[16:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign quotient  = q_q;
	assign remainder = r_q[15:0];
endmodule

// ===== rtl/core/htw_cell.sv =====
`timescale 1ns / 1ps
// One timer entry. The free flag ripples along the row; the fire request does not.
module htw_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  htw_pkg::cell_cmd_t  cmd,
	input  logic                sel_del,
	input  logic                take_in,
	output logic                take_out,
	input  logic                fire_clr,
	output logic                valid,
	output logic                fire
);
	import htw_pkg::*;

	logic        valid_q;
	logic        fire_q;
	logic [15:0] slot_q;
	logic [31:0] rot_q;
	logic        hit;

	// take_in high means no lower cell took the add
	assign take_out = take_in & valid_q;
	assign hit = valid_q && (slot_q == cmd.cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			fire_q  <= 1'b0;
		end else begin
			if (cmd.add && take_in && !valid_q) valid_q <= 1'b1;
			if (cmd.del && sel_del) valid_q <= 1'b0;
			if (cmd.tick && hit && rot_q == '0) begin
				valid_q <= 1'b0;
				fire_q  <= 1'b1;
			end
			if (fire_clr) fire_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add && take_in && !valid_q) begin
			slot_q <= cmd.slot;
			rot_q  <= cmd.rot;
		end else if (cmd.tick && hit && rot_q != '0) begin
			rot_q <= rot_q - 32'd1;
		end
	end

	assign valid = valid_q;
	assign fire  = fire_q;
endmodule

// ===== bench/tb_hashed_timer_wheel_unit.sv =====
`timescale 1ns / 1ps
module tb_hashed_timer_wheel_unit;
	import htw_pkg::*;

	localparam int unsigned POOL = 32;
	localparam int unsigned SLOTS_MAX = 1024;
	localparam int unsigned STALL_LIMIT = 20000;

	typedef struct packed {
		logic [4:0]  target;
		logic [31:0] timeout;
		op_t         op;
	} cmd_t;

	typedef struct packed {
		logic    last;
		logic    expired;
		logic [4:0] id;
		status_t status;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // operation, timeout_ticks, target_timer
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // status, timer_id, expired
	logic        m_axis_tlast;   // last_of_run
	logic        cfg_we;
	logic [10:0] cfg_wdata;

	// predictor state
	logic        live [POOL] = '{default: 1'b0};
	logic [9:0]  home [POOL];
	logic [31:0] laps [POOL];
	logic [9:0]  hand = '0;
	logic [10:0] slot_reg;

	cmd_t   pending_cmds[$];
	reply_t expected_replies[$];
	int     mismatches = 0;
	int     quiet_cycles = 0;
	int     gap_left;
	int     hold_left;
	int     hold_long = 0;
	bit     hold_go = 1'b0;
	bit     hold_armed = 1'b0;
	bit     feed_paused;

	hashed_timer_wheel_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void expect_reply(reply_t r);
		expected_replies.insert(expected_replies.size(), r);
	endfunction

	function automatic void queue_cmd(cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	function automatic int unsigned wheel_size();
		int unsigned n;
		n = 32'(slot_reg);
		if (n < 1) n = 1;
		if (n > SLOTS_MAX) n = SLOTS_MAX;
		return n;
	endfunction

	function automatic reply_t mk(status_t st, int id, bit ex, bit last);
		reply_t r;
		r.status = st;
		r.id = id[4:0];
		r.expired = ex;
		r.last = last;
		return r;
	endfunction

	task automatic predict_wheel(input cmd_t c);
		int unsigned n;
		int fired;
		int i;
		bit done;
		n = wheel_size();
		fired = 0;
		done = 0;
		case (c.op)
			OP_ADD: begin
				for (i = 0; i < POOL && !done; i++) begin
					if (!live[i]) begin
						live[i] = 1'b1;
						home[i] = 10'((hand + c.timeout % n) % n);
						laps[i] = c.timeout / n;
						expect_reply(mk(ST_OK, i, 1'b0, 1'b1));
						done = 1;
					end
				end
				if (!done) expect_reply(mk(ST_FULL, 0, 1'b0, 1'b1));
			end
			OP_DEL: begin
				if (live[c.target]) begin
					live[c.target] = 1'b0;
					expect_reply(mk(ST_OK, int'(c.target), 1'b0, 1'b1));
				end else begin
					expect_reply(mk(ST_NOTFOUND, int'(c.target), 1'b0, 1'b1));
				end
			end
			OP_TICK: begin
				for (i = 0; i < POOL; i++) begin
					if (live[i] && home[i] == hand) begin
						if (laps[i] > 0) begin
							laps[i]--;
						end else begin
							live[i] = 1'b0;
							expect_reply(mk(ST_OK, i, 1'b1, 1'b0));
							fired++;
						end
					end
				end
				hand = 10'((hand + 1) % n);
				if (fired == 0) expect_reply(mk(ST_OK, 0, 1'b0, 1'b1));
				else expected_replies[$].last = 1'b1;
			end
			default: expect_reply(mk(ST_OK, 0, 1'b0, 1'b1));
		endcase
	endtask

	function automatic cmd_t make_cmd(op_t op, logic [31:0] t, logic [4:0] tg);
		cmd_t c;
		c.op = op;
		c.timeout = t;
		c.target = tg;
		return c;
	endfunction

	function automatic int short_or_long_gap();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
		return $urandom_range(0, 3);
	endfunction

	// driver: accept on handshake, then present the next command
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			gap_left <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_wheel(cmd_t'(s_axis_tdata[38:0]));
				void'(pending_cmds.pop_front());
				s_axis_tvalid <= 1'b0;
				gap_left <= short_or_long_gap();
			end else if (!s_axis_tvalid) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (!feed_paused && pending_cmds.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {1'b0, pending_cmds[0]};
				end
			end
		end
	end

	// monitor: compare each result transaction against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = mk(status_t'(m_axis_tdata[1:0]), int'(m_axis_tdata[6:2]),
					m_axis_tdata[7], m_axis_tlast);
				if (expected_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = expected_replies.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display(
								"exp st=%0d id=%0d ex=%b last=%b got st=%0d id=%0d ex=%b last=%b",
								want.status, want.id, want.expired, want.last,
								got.status, got.id, got.expired, got.last);
					end
				end
			end
			if (hold_long > 0) begin
				m_axis_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				hold_left <= short_or_long_gap();
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_go && !hold_armed) begin
			hold_long <= 400;
			hold_armed <= 1'b1;
		end else if (hold_long > 0) begin
			hold_long <= hold_long - 1;
		end
	end

	// watchdog on accepted transactions
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (pending_cmds.size() == 0 && expected_replies.size() == 0)
				|| hold_long > 0) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("hashed_timer_wheel_unit: mismatch");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pending_cmds.size() > 0 || expected_replies.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_wheel(input logic [10:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		slot_reg = v;
	endtask

	// random traffic: adds with mostly short timeouts, ticks to fire them, some deletes and idle ops
	task automatic queue_random(input int count, input int unsigned tmax);
		int k;
		int sel;
		logic [31:0] t;
		for (k = 0; k < count; k++) begin
			sel = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0) t = $urandom();
			else t = $urandom_range(0, tmax);
			if (sel < 35) queue_cmd(make_cmd(OP_ADD, t, 5'($urandom())));
			else if (sel < 50) queue_cmd(make_cmd(OP_DEL, $urandom(), 5'($urandom())));
			else if (sel < 97) queue_cmd(make_cmd(OP_TICK, $urandom(), 5'($urandom())));
			else queue_cmd(make_cmd(OP_NONE, $urandom(), 5'($urandom())));
		end
	endtask

	initial begin
		int k;
		slot_reg = 11'd1024;
		feed_paused = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every op, full pool, free deletes, wrapping
		queue_cmd(make_cmd(OP_ADD, 32'd0, 5'd0));
		queue_cmd(make_cmd(OP_ADD, 32'hFFFF_FFFF, 5'd31));
		queue_cmd(make_cmd(OP_ADD, 32'd1024, 5'd0));
		queue_cmd(make_cmd(OP_DEL, 32'hFFFF_FFFF, 5'd1));
		queue_cmd(make_cmd(OP_DEL, 32'd0, 5'd31));
		queue_cmd(make_cmd(OP_NONE, 32'hFFFF_FFFF, 5'd31));
		queue_cmd(make_cmd(OP_TICK, 32'd0, 5'd0));
		queue_cmd(make_cmd(OP_TICK, 32'hFFFF_FFFF, 5'd31));
		drain();

		set_wheel(11'd1);
		for (k = 0; k < 33; k++)
			queue_cmd(make_cmd(OP_ADD, 32'(k % 3), 5'd0));
		for (k = 0; k < 4; k++)
			queue_cmd(make_cmd(OP_TICK, 32'd0, 5'd0));

		set_wheel(11'd0);
		queue_random(60, 4);
		set_wheel(11'd2047);
		queue_random(40, 3);

		set_wheel(11'd4);
		queue_random(80, 12);
		// long hold-off at the receiver while commands pile up behind it
		drain();
		hold_go = 1'b1;
		queue_random(20, 8);
		drain();

		// pause the sender mid-stream until everything is back
		queue_random(10, 8);
		repeat (40) @(posedge clk);
		feed_paused = 1'b1;
		while (expected_replies.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (20) @(posedge clk);
		feed_paused = 1'b0;

		set_wheel(11'd2);
		queue_random(60, 6);
		set_wheel(11'd1024);
		queue_random(30, 2000);
		set_wheel(11'd7);
		queue_random(100, 30);
		drain();

		if (mismatches == 0) begin
			$display("hashed_timer_wheel_unit: match");
		end else begin
			$display("hashed_timer_wheel_unit: mismatch");
		end
		$finish;
	end
endmodule

// ===== hashed_timer_wheel_unit.f =====
+incdir+rtl/core
rtl/core/htw_pkg.sv
rtl/core/htw_divider.sv
rtl/core/htw_cell.sv
rtl/core/hashed_timer_wheel_unit.sv
bench/tb_hashed_timer_wheel_unit.sv
